// ===== sv/script_comment_stripper_top_defines.svh =====
// Assertion macros for the script comment stripper RTL.
`ifndef SCRIPT_COMMENT_STRIPPER_TOP_DEFINES_SVH
`define SCRIPT_COMMENT_STRIPPER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define SCS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define SCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define SCS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SCS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/scs_pkg.sv =====
`timescale 1ns / 1ps

package scs_pkg;

   localparam int DEPTH_BITS = 8;
   localparam int CMP_W      = (DEPTH_BITS > 8) ? DEPTH_BITS + 1 : 9;

   localparam logic [DEPTH_BITS-1:0] DEPTH_TOP = {DEPTH_BITS{1'b1}};
   localparam logic [7:0]            MAX_DEPTH_RESET = 8'd255;

   // characters
   localparam logic [7:0] CH_EOS   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNTERM  = 2'd1;
   localparam logic [1:0] ST_LIMIT   = 2'd2;

   typedef enum logic [1:0] {
      PM_NONE  = 2'd0,
      PM_SLASH = 2'd1,
      PM_STAR  = 2'd2
   } pm_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic [7:0] c, input logic v,
                                        input logic [1:0] st);
      rsp_type r;
      r.out_char   = c;
      r.char_valid = v;
      r.status     = st;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic logic lead_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LPAR) ||
             (c == CH_RPAR) || (c == CH_COMMA);
   endfunction

endpackage

// ===== sv/script_comment_stripper_top.sv =====
`timescale 1ns / 1ps
// Script comment stripper.
// Input channel (req_valid / req_stall / req_ch): one source byte per transfer.
// Result channel (rsp_valid / rsp_stall / rsp_*): cleaned characters, 0, 1 or 2
// per input byte; rsp_last marks the final result caused by an input byte.
// Status results: nesting limit hits (char_valid 0) and the end-of-stream
// result (out_char 0) with the unterminated-comment flag.
// Config: csr_write_enable / csr_write_data load max_comment_depth (reset 255);
// write only while the block is idle.
// A byte's results, if any, are written to the result buffer when the byte is
// taken, with rsp_valid high in the following cycle.
// Throughput: one byte per cycle while rsp_stall is low and each byte gives at
// most one result; a byte that gives two results fills the two-entry result
// buffer. A byte is taken only when the buffer is empty after the
// current output transfer, so req_stall follows rsp_stall combinationally.
// Reset (synchronous, active high) clears the parser state, empties the
// buffer and sets max_comment_depth to 255. Byte 0 also clears the parser
// state but keeps max_comment_depth.
// When the receiver stalls, the head result holds and input is stalled
// once the buffer cannot take another two results.
`include "script_comment_stripper_top_defines.svh"

module script_comment_stripper_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic [1:0] rsp_status,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   // parser state
   logic [scs_pkg::DEPTH_BITS-1:0] depth_ff, depth_in;
   scs_pkg::pm_type                pm_ff, pm_in;
   logic                           skip_lf_ff, skip_lf_in;
   logic                           line_start_ff, line_start_in;
   logic                           in_quotes_ff, in_quotes_in;
   logic                           in_lc_ff, in_lc_in;
   logic [7:0]                     max_depth_ff;

   // result buffer: slot 0 is the head
   scs_pkg::rsp_type slot0_ff, slot0_in;
   scs_pkg::rsp_type slot1_ff, slot1_in;
   logic [1:0]       cnt_ff, cnt_in;

   logic             req_acc;
   logic             rsp_pop;
   scs_pkg::rsp_type res_v [2];
   logic [1:0]       n_v;
   logic             held_slash;
   logic             done_v;
   logic             at_limit;

   assign rsp_pop   = (cnt_ff != 2'd0) && !rsp_stall;
   assign req_stall = !((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_pop));
   assign req_acc   = req_valid && !req_stall;

   assign rsp_valid      = (cnt_ff != 2'd0);
   assign rsp_out_char   = slot0_ff.out_char;
   assign rsp_char_valid = slot0_ff.char_valid;
   assign rsp_status     = slot0_ff.status;
   assign rsp_last       = slot0_ff.last;

   assign held_slash = (depth_ff == '0) && !in_lc_ff && (pm_ff == scs_pkg::PM_SLASH);
   assign at_limit   = (scs_pkg::CMP_W'(depth_ff) >= scs_pkg::CMP_W'(max_depth_ff)) ||
                       (depth_ff == scs_pkg::DEPTH_TOP);

   // per-byte parse: next state and up to two results
   always_comb begin
      depth_in      = depth_ff;
      pm_in         = pm_ff;
      skip_lf_in    = skip_lf_ff;
      line_start_in = line_start_ff;
      in_quotes_in  = in_quotes_ff;
      in_lc_in      = in_lc_ff;
      res_v[0]      = scs_pkg::make_rsp(8'h00, 1'b0, scs_pkg::ST_OK);
      res_v[1]      = scs_pkg::make_rsp(8'h00, 1'b0, scs_pkg::ST_OK);
      n_v           = 2'd0;
      done_v        = 1'b0;

      if (req_ch == scs_pkg::CH_EOS) begin
         if (held_slash) begin
            res_v[n_v[0]] = scs_pkg::make_rsp(scs_pkg::CH_SLASH, 1'b1, scs_pkg::ST_OK);
            n_v = n_v + 2'd1;
         end
         res_v[n_v[0]] = scs_pkg::make_rsp(scs_pkg::CH_EOS, 1'b1,
            (depth_ff != '0) ? scs_pkg::ST_UNTERM : scs_pkg::ST_OK);
         n_v = n_v + 2'd1;
         depth_in      = '0;
         pm_in         = scs_pkg::PM_NONE;
         skip_lf_in    = 1'b0;
         line_start_in = 1'b1;
         in_quotes_in  = 1'b0;
         in_lc_in      = 1'b0;
      end else if (skip_lf_ff && (req_ch == scs_pkg::CH_LF)) begin
         skip_lf_in = 1'b0;  // second half of CRLF
      end else if ((req_ch == scs_pkg::CH_CR) || (req_ch == scs_pkg::CH_LF)) begin
         if (held_slash) begin
            res_v[n_v[0]] = scs_pkg::make_rsp(scs_pkg::CH_SLASH, 1'b1, scs_pkg::ST_OK);
            n_v = n_v + 2'd1;
         end
         pm_in         = scs_pkg::PM_NONE;
         in_lc_in      = 1'b0;
         line_start_in = 1'b1;
         in_quotes_in  = 1'b0;
         skip_lf_in    = (req_ch == scs_pkg::CH_CR);
         res_v[n_v[0]] = scs_pkg::make_rsp(scs_pkg::CH_LF, 1'b1, scs_pkg::ST_OK);
         n_v = n_v + 2'd1;
      end else if (in_lc_ff) begin
         skip_lf_in = 1'b0;
      end else if (depth_ff != '0) begin
         skip_lf_in = 1'b0;
         if ((pm_ff == scs_pkg::PM_SLASH) && (req_ch == scs_pkg::CH_STAR)) begin
            pm_in = scs_pkg::PM_NONE;
            if (at_limit) begin
               res_v[0] = scs_pkg::make_rsp(8'h00, 1'b0, scs_pkg::ST_LIMIT);
               n_v = 2'd1;
            end else begin
               depth_in = depth_ff + 1'b1;
            end
         end else if ((pm_ff == scs_pkg::PM_STAR) && (req_ch == scs_pkg::CH_SLASH)) begin
            pm_in    = scs_pkg::PM_NONE;
            depth_in = depth_ff - 1'b1;
            // comment closed after text on this line: becomes one space
            if ((depth_in == '0) && !line_start_ff) begin
               res_v[0] = scs_pkg::make_rsp(scs_pkg::CH_SPACE, 1'b1, scs_pkg::ST_OK);
               n_v = 2'd1;
            end
         end else begin
            pm_in = (req_ch == scs_pkg::CH_SLASH) ? scs_pkg::PM_SLASH :
                    (req_ch == scs_pkg::CH_STAR)  ? scs_pkg::PM_STAR  : scs_pkg::PM_NONE;
         end
      end else begin
         skip_lf_in = 1'b0;
         pm_in      = scs_pkg::PM_NONE;
         if (held_slash) begin
            if (req_ch == scs_pkg::CH_STAR) begin
               depth_in = scs_pkg::DEPTH_BITS'(1);
               done_v   = 1'b1;
            end else if (req_ch == scs_pkg::CH_SLASH) begin
               in_lc_in = 1'b1;
               done_v   = 1'b1;
            end else begin
               // lone slash is plain text
               res_v[0] = scs_pkg::make_rsp(scs_pkg::CH_SLASH, 1'b1, scs_pkg::ST_OK);
               n_v = 2'd1;
               line_start_in = 1'b0;
            end
         end
         if (!done_v) begin
            if (line_start_in && scs_pkg::lead_blank(req_ch)) begin
               // leading filler dropped
            end else if (!in_quotes_ff && (req_ch == scs_pkg::CH_SLASH)) begin
               pm_in = scs_pkg::PM_SLASH;
            end else begin
               line_start_in = 1'b0;
               if (req_ch == scs_pkg::CH_QUOTE) begin
                  in_quotes_in = !in_quotes_ff;
               end
               res_v[n_v[0]] = scs_pkg::make_rsp(req_ch, 1'b1, scs_pkg::ST_OK);
               n_v = n_v + 2'd1;
            end
         end
      end

      if (n_v == 2'd1) begin
         res_v[0].last = 1'b1;
      end else if (n_v == 2'd2) begin
         res_v[1].last = 1'b1;
      end
   end

   // buffer update: an accepted byte always finds the buffer empty after pop
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (req_acc) begin
         slot0_in = res_v[0];
         slot1_in = res_v[1];
         cnt_in   = n_v;
      end else if (rsp_pop) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         cnt_ff        <= 2'd0;
         depth_ff      <= '0;
         pm_ff         <= scs_pkg::PM_NONE;
         skip_lf_ff    <= 1'b0;
         line_start_ff <= 1'b1;
         in_quotes_ff  <= 1'b0;
         in_lc_ff      <= 1'b0;
         max_depth_ff  <= scs_pkg::MAX_DEPTH_RESET;
      end else begin
         cnt_ff <= cnt_in;
         if (req_acc) begin
            depth_ff      <= depth_in;
            pm_ff         <= pm_in;
            skip_lf_ff    <= skip_lf_in;
            line_start_ff <= line_start_in;
            in_quotes_ff  <= in_quotes_in;
            in_lc_ff      <= in_lc_in;
         end
         if (csr_write_enable) begin
            max_depth_ff <= csr_write_data;
         end
      end
   end

   // assertions
   `SCS_ASSERT_IMPLIES(a_cnt_range, clock, reset, 1'b1, cnt_ff != 2'd3)
   `SCS_ASSERT_IMPLIES(a_tail_last, clock, reset, cnt_ff == 2'd2,
      slot1_ff.last && !slot0_ff.last)
   `SCS_ASSERT_IMPLIES(a_lc_not_nested, clock, reset, in_lc_ff, depth_ff == '0)
   `SCS_ASSERT_IMPLIES(a_star_in_comment, clock, reset, pm_ff == scs_pkg::PM_STAR,
      depth_ff != '0)
   `SCS_ASSERT_NEXT(a_eos_clears, clock, reset, req_acc && (req_ch == scs_pkg::CH_EOS),
      (depth_ff == '0) && line_start_ff && !in_quotes_ff && !in_lc_ff)

endmodule

// ===== sim/cleaned_stream_checker.sv =====
`timescale 1ns / 1ps

module cleaned_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_char,
   input  logic       rsp_char_valid,
   input  logic [1:0] rsp_status,
   input  logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       end_of_run,
   output int         fail_count,
   output int         pending_count,
   output int         results_checked
);

   scs_pkg::rsp_type               cleaned_q[$];
   logic [7:0]                     depth_limit;
   logic [scs_pkg::DEPTH_BITS-1:0] nest;
   scs_pkg::pm_type                mark;
   logic                           skip_lf;
   logic                           at_line_start;
   logic                           quoted;
   logic                           in_line_cmt;
   int                             mismatches;
   int                             checked;

   function automatic logic drops_at_line_start(input logic [7:0] c);
      case (c)
         scs_pkg::CH_SPACE, scs_pkg::CH_TAB, scs_pkg::CH_LPAR, scs_pkg::CH_RPAR,
         scs_pkg::CH_COMMA: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function void restart_parse();
      nest          = '0;
      mark          = scs_pkg::PM_NONE;
      skip_lf       = 1'b0;
      at_line_start = 1'b1;
      quoted        = 1'b0;
      in_line_cmt   = 1'b0;
   endfunction

   function void queue_result(input logic [7:0] c, input logic v, input logic [1:0] st);
      scs_pkg::rsp_type r;
      r.out_char   = c;
      r.char_valid = v;
      r.status     = st;
      r.last       = 1'b0;
      cleaned_q.push_back(r);
   endfunction

   // expected output of one source byte, appended to cleaned_q
   function void clean_byte(input logic [7:0] ch);
      logic             slash_held;
      logic             opened;
      int               before_n;
      scs_pkg::rsp_type tail;
      before_n   = cleaned_q.size();
      slash_held = (nest == '0) && !in_line_cmt && (mark == scs_pkg::PM_SLASH);
      opened     = 1'b0;
      if (ch == scs_pkg::CH_EOS) begin
         if (slash_held)
            queue_result(scs_pkg::CH_SLASH, 1'b1, scs_pkg::ST_OK);
         queue_result(scs_pkg::CH_EOS, 1'b1,
                      (nest != '0) ? scs_pkg::ST_UNTERM : scs_pkg::ST_OK);
         restart_parse();
      end else if (skip_lf && ch == scs_pkg::CH_LF) begin
         skip_lf = 1'b0;
      end else if (ch == scs_pkg::CH_CR || ch == scs_pkg::CH_LF) begin
         if (slash_held)
            queue_result(scs_pkg::CH_SLASH, 1'b1, scs_pkg::ST_OK);
         mark          = scs_pkg::PM_NONE;
         in_line_cmt   = 1'b0;
         at_line_start = 1'b1;
         quoted        = 1'b0;
         skip_lf       = (ch == scs_pkg::CH_CR);
         queue_result(scs_pkg::CH_LF, 1'b1, scs_pkg::ST_OK);
      end else if (in_line_cmt) begin
         skip_lf = 1'b0;
      end else if (nest != '0) begin
         skip_lf = 1'b0;
         if (mark == scs_pkg::PM_SLASH && ch == scs_pkg::CH_STAR) begin
            mark = scs_pkg::PM_NONE;
            if (nest >= depth_limit || nest == scs_pkg::DEPTH_TOP)
               queue_result(8'h00, 1'b0, scs_pkg::ST_LIMIT);
            else
               nest = nest + 1'b1;
         end else if (mark == scs_pkg::PM_STAR && ch == scs_pkg::CH_SLASH) begin
            mark = scs_pkg::PM_NONE;
            nest = nest - 1'b1;
            if (nest == '0 && !at_line_start)
               queue_result(scs_pkg::CH_SPACE, 1'b1, scs_pkg::ST_OK);
         end else if (ch == scs_pkg::CH_SLASH) begin
            mark = scs_pkg::PM_SLASH;
         end else if (ch == scs_pkg::CH_STAR) begin
            mark = scs_pkg::PM_STAR;
         end else begin
            mark = scs_pkg::PM_NONE;
         end
      end else begin
         skip_lf = 1'b0;
         mark    = scs_pkg::PM_NONE;
         if (slash_held) begin
            if (ch == scs_pkg::CH_STAR) begin
               nest   = scs_pkg::DEPTH_BITS'(1);
               opened = 1'b1;
            end else if (ch == scs_pkg::CH_SLASH) begin
               in_line_cmt = 1'b1;
               opened      = 1'b1;
            end else begin
               queue_result(scs_pkg::CH_SLASH, 1'b1, scs_pkg::ST_OK);
               at_line_start = 1'b0;
            end
         end
         if (!opened) begin
            if (at_line_start && drops_at_line_start(ch)) begin
               // leading filler, nothing emitted
            end else if (!quoted && ch == scs_pkg::CH_SLASH) begin
               mark = scs_pkg::PM_SLASH;
            end else begin
               at_line_start = 1'b0;
               if (ch == scs_pkg::CH_QUOTE)
                  quoted = !quoted;
               queue_result(ch, 1'b1, scs_pkg::ST_OK);
            end
         end
      end
      if (cleaned_q.size() > before_n) begin
         tail      = cleaned_q.pop_back();
         tail.last = 1'b1;
         cleaned_q.push_back(tail);
      end
   endfunction

   always @(posedge clock) begin : watch
      scs_pkg::rsp_type want;
      if (reset) begin
         depth_limit = scs_pkg::MAX_DEPTH_RESET;
         restart_parse();
         cleaned_q.delete();
      end else begin
         if (csr_write_enable)
            depth_limit = csr_write_data;
         // result transfer first: it can only stem from an earlier byte
         if (rsp_valid && !rsp_stall) begin
            if (cleaned_q.size() == 0) begin
               $error("unexpected result: out_char %02h status %0d", rsp_out_char, rsp_status);
               mismatches++;
            end else begin
               want = cleaned_q.pop_front();
               checked++;
               if (rsp_out_char !== want.out_char) begin
                  $error("out_char: expected %02h, got %02h", want.out_char, rsp_out_char);
                  mismatches++;
               end
               if (rsp_char_valid !== want.char_valid) begin
                  $error("char_valid: expected %0b, got %0b", want.char_valid, rsp_char_valid);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            clean_byte(req_ch);
         if (end_of_run && cleaned_q.size() != 0) begin
            $error("%0d expected results never arrived", cleaned_q.size());
            mismatches += cleaned_q.size();
            cleaned_q.delete();
         end
      end
      fail_count      <= mismatches;
      pending_count   <= cleaned_q.size();
      results_checked <= checked;
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int HOLD_CYCLES = 300;     // long output hold-off to back up the block
   localparam int CYCLE_LIMIT = 400000;  // watchdog, far above the slowest legal run

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_ch;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_char;
   logic       rsp_char_valid;
   logic [1:0] rsp_status;
   logic       rsp_last;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   logic       end_of_run;
   bit         calm;           // no idling on either side while set
   bit         hold_request;   // asks the receiver for one long hold-off
   int         bytes_sent;
   int         fail_count;
   int         pending_count;
   int         results_checked;
   int         cycle_count;
   logic [7:0] frag_q[$];      // bytes of the next random source fragment

   script_comment_stripper_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Checker sits beside the block: it sees every transfer on both channels and
   // every register write, predicts the cleaned stream and compares.
   cleaned_stream_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .end_of_run       (end_of_run),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .results_checked  (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: ends the run if the stimulus or the block hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("watchdog expired after %0d cycles", cycle_count);
      $display("** script_comment_stripper_top: FAILED **");
      $finish;
   end

   // Receiver: random stalls, a calm stretch, and one long hold-off counted here.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 11);
         end
      end
   end

   // One input transfer. Valid stays high between back-to-back bytes; an idle
   // gap lowers it first. The payload is only changed when a new byte starts,
   // so a stalled byte holds steady.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (!calm && $urandom_range(99) < 5) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   // Drop valid, wait for every expected result, and then wait out a byte that is
   // still in flight but produces nothing.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_depth_limit(input logic [7:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly identifier-like text, with the odd comment mark and stray byte.
   function automatic void add_word(input int len);
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(9);
         if (r < 6)
            frag_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
         else if (r == 6)
            frag_q.push_back(8'($urandom_range(8'h30, 8'h39)));
         else if (r == 7)
            frag_q.push_back(scs_pkg::CH_STAR);
         else if (r == 8)
            frag_q.push_back(scs_pkg::CH_SLASH);
         else
            frag_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end
   endfunction

   // Random fragment of script source: mostly well formed pieces (words, line
   // ends, strings, line and nested block comments), the rest noise.
   task automatic build_fragment();
      int kind;
      int lvl;
      frag_q.delete();
      kind = $urandom_range(99);
      if (kind < 22) begin
         add_word($urandom_range(1, 6));
      end else if (kind < 32) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(4))
               0:       frag_q.push_back(scs_pkg::CH_SPACE);
               1:       frag_q.push_back(scs_pkg::CH_TAB);
               2:       frag_q.push_back(scs_pkg::CH_LPAR);
               3:       frag_q.push_back(scs_pkg::CH_RPAR);
               default: frag_q.push_back(scs_pkg::CH_COMMA);
            endcase
         end
      end else if (kind < 42) begin
         case ($urandom_range(2))
            0: frag_q.push_back(scs_pkg::CH_LF);
            1: frag_q.push_back(scs_pkg::CH_CR);
            default: begin
               frag_q.push_back(scs_pkg::CH_CR);
               frag_q.push_back(scs_pkg::CH_LF);
            end
         endcase
      end else if (kind < 52) begin
         // quoted text, sometimes holding a comment mark, sometimes left open
         frag_q.push_back(scs_pkg::CH_QUOTE);
         add_word($urandom_range(0, 4));
         if ($urandom_range(3) == 0) begin
            frag_q.push_back(scs_pkg::CH_SLASH);
            frag_q.push_back(($urandom_range(1) != 0) ? scs_pkg::CH_SLASH : scs_pkg::CH_STAR);
         end
         add_word($urandom_range(0, 3));
         if ($urandom_range(3) != 0)
            frag_q.push_back(scs_pkg::CH_QUOTE);
      end else if (kind < 60) begin
         frag_q.push_back(scs_pkg::CH_SLASH);
         frag_q.push_back(scs_pkg::CH_SLASH);
         add_word($urandom_range(0, 6));
      end else if (kind < 80) begin
         // nested block comment, rarely left unterminated
         lvl = $urandom_range(1, 4);
         repeat (lvl) begin
            frag_q.push_back(scs_pkg::CH_SLASH);
            frag_q.push_back(scs_pkg::CH_STAR);
            add_word($urandom_range(0, 4));
            if ($urandom_range(7) == 0)
               frag_q.push_back(scs_pkg::CH_LF);
         end
         if ($urandom_range(9) != 0) begin
            repeat (lvl) begin
               add_word($urandom_range(0, 3));
               frag_q.push_back(scs_pkg::CH_STAR);
               frag_q.push_back(scs_pkg::CH_SLASH);
            end
         end
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 3))
            frag_q.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 96) begin
         case ($urandom_range(2))
            0:       frag_q.push_back(scs_pkg::CH_SLASH);
            1:       frag_q.push_back(scs_pkg::CH_STAR);
            default: begin
               frag_q.push_back(scs_pkg::CH_SLASH);
               add_word(1);
            end
         endcase
      end else if (kind < 98) begin
         frag_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
      end else begin
         frag_q.push_back(scs_pkg::CH_EOS);
      end
   endtask

   task automatic run_random(input int n_bytes, input bit pause_midway);
      int sent;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < n_bytes) begin
         build_fragment();
         foreach (frag_q[i])
            send_byte(frag_q[i]);
         sent += frag_q.size();
         // sender waits until the block has delivered everything
         if (pause_midway && !paused && sent >= n_bytes / 2) begin
            settle();
            paused = 1'b1;
         end
      end
      send_byte(scs_pkg::CH_EOS);
   endtask

   // Drive the nesting counter to its top, one opening past it, then close all.
   task automatic nest_to_top();
      send_byte(8'h61);
      for (int i = 0; i < int'(scs_pkg::DEPTH_TOP) + 1; i++) begin
         send_byte(scs_pkg::CH_SLASH);
         send_byte(scs_pkg::CH_STAR);
      end
      for (int i = 0; i < int'(scs_pkg::DEPTH_TOP); i++) begin
         send_byte(scs_pkg::CH_STAR);
         send_byte(scs_pkg::CH_SLASH);
      end
      send_byte(scs_pkg::CH_EOS);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_ch           = 8'h00;
      csr_write_enable = 1'b0;
      csr_write_data   = 8'h00;
      end_of_run       = 1'b0;
      calm             = 1'b0;
      hold_request     = 1'b0;
      bytes_sent       = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, limit at its reset value: leading filler, lone slash before a
      // letter, slashes in quotes, CRLF, nested comment across a line, a comment
      // closing mid-line, a held slash at end of stream.
      send_text(" \t(,)a\377/b\"//\015\n/*/*\n*/*/q/*k*/ /");
      send_byte(scs_pkg::CH_EOS);
      send_text("/*a");          // unterminated at end of stream
      send_byte(scs_pkg::CH_EOS);
      send_text("//c");          // end of stream inside a line comment is fine
      send_byte(scs_pkg::CH_EOS);

      // Smallest limit: second opening is flagged, not counted.
      settle();
      write_depth_limit(8'd1);
      send_text("/*/*x*/*/");
      send_byte(scs_pkg::CH_EOS);
      run_random(40, 1'b0);

      // Largest limit: nesting runs into the counter top.
      settle();
      write_depth_limit(8'd255);
      nest_to_top();
      run_random(40, 1'b0);

      // Receiver holds off for a long stretch while bytes keep coming.
      settle();
      write_depth_limit(8'd2);
      hold_request = 1'b1;
      run_random(50, 1'b0);

      // Full-rate stretch, no idling on either side.
      settle();
      write_depth_limit(8'($urandom_range(3, 254)));
      calm = 1'b1;
      run_random(120, 1'b0);
      calm = 1'b0;

      // Sender pauses midway until every result has been delivered.
      settle();
      write_depth_limit(8'($urandom_range(1, 8)));
      run_random(60, 1'b1);

      settle();
      write_depth_limit(8'd128);
      run_random(50, 1'b0);

      settle();
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Sent %0d source bytes, checked %0d results; depth limits 1 to 255,",
               bytes_sent, results_checked);
      $display("counter-top nesting, limit hits, open comments, long hold and full rate.");
      if (fail_count == 0) begin
         $display("** script_comment_stripper_top: PASSED **");
      end else begin
         $display("** script_comment_stripper_top: FAILED **");
      end
      $finish;
   end

endmodule
